// ===== sv/apdh_pkg.sv =====
// shared types, constants and helpers for the atom-pair descriptor histogram
// no dependencies; every other file but apdh_ram imports this package
package apdh_pkg;

  // stored bins
  localparam int BIN_COUNT = 4096;
  localparam int BIN_AW    = $clog2(BIN_COUNT);

  // field and datapath widths
  localparam int TYPE_W = 6;
  localparam int LIM_W  = 4;
  localparam int CNT_W  = 8;
  localparam int BIDX_W = 12;
  localparam int AP_W   = 11;   // pair span, up to 2016
  localparam int APC_W  = 15;   // pair span times cyclic slots, up to 32256
  localparam int IND_W  = 19;   // full computed index, up to 516095
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLIC_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACYCLIC_LIMIT = 2'd2;

  // action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ACC   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [1:0] {
    K_NONE,
    K_CLEAR,
    K_ACC,
    K_READ
  } kind_t;

  // one classified job handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [IND_W-1:0]   ind;
    logic [IND_W-1:0]   len;
    logic [AP_W-1:0]    ap;
    logic [APC_W-1:0]   apc;
  } job_t;

  // triangular number n*(n+1)/2 of a type code
  function automatic logic [AP_W-1:0] tri6(input logic [TYPE_W-1:0] n);
    logic [12:0] p;
    p = 13'(n) * (13'(n) + 13'd1);
    return p[AP_W:1];
  endfunction

endpackage

// ===== sv/apdh_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module apdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/apdh_front.sv =====
// front end: configuration registers, input acceptance, pair ordering and index build
// depends on apdh_pkg
module apdh_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [apdh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apdh_pkg::TYPE_W-1:0]        cfg_data,
  input  logic                               hold,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic [apdh_pkg::TYPE_W-1:0]        type_first,
  input  logic [apdh_pkg::TYPE_W-1:0]        type_second,
  input  logic [7:0]                         cyclic_bonds,
  input  logic [7:0]                         acyclic_bonds,
  input  logic [apdh_pkg::BIDX_W-1:0]        bin_index,
  output logic                               push,
  output apdh_pkg::job_t                     job,
  input  logic                               full
);
  import apdh_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL1 = 2'd1;
  localparam logic [1:0] F_MUL2 = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]        state;
  logic [TYPE_W-1:0] type_count;
  logic [LIM_W-1:0]  cyc_lim;
  logic [LIM_W-1:0]  acyc_lim;

  kind_t             kind;
  logic [TYPE_W-1:0] lo;
  logic [AP_W-1:0]   tri_hi;
  logic [AP_W-1:0]   ap;
  logic [LIM_W-1:0]  nc;
  logic [LIM_W-1:0]  na;
  logic [BIDX_W-1:0] bi;
  logic [APC_W-1:0]  apc;
  logic [APC_W-1:0]  apnc;
  logic [IND_W-1:0]  apcna;
  logic [IND_W-1:0]  len;

  logic              accept;
  logic              bonds_ok;
  logic              first_big;
  kind_t             kind_next;
  logic [4:0]        c1;
  logic [4:0]        d1;
  logic [15:0]       apc_full;
  logic [15:0]       apnc_full;
  logic [19:0]       apcna_full;
  logic [19:0]       len_full;
  logic [IND_W-1:0]  ind_sum;

  assign in_stall = (state != F_IDLE) || hold;
  assign accept   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      type_count <= 6'd8;
      cyc_lim    <= 4'd7;
      acyc_lim   <= 4'd7;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TYPE_COUNT:    type_count <= cfg_data;
        REG_CYCLIC_LIMIT:  cyc_lim    <= cfg_data[LIM_W-1:0];
        REG_ACYCLIC_LIMIT: acyc_lim   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // classify the incoming word
  always_comb begin
    bonds_ok  = (cyclic_bonds <= 8'(cyc_lim)) && (acyclic_bonds <= 8'(acyc_lim));
    first_big = type_first > type_second;
    unique case (action)
      ACT_CLEAR: kind_next = K_CLEAR;
      ACT_ACC:   kind_next = bonds_ok ? K_ACC : K_NONE;
      ACT_READ:  kind_next = K_READ;
      default:   kind_next = K_NONE;
    endcase
  end

  // index arithmetic, one multiply level per step
  always_comb begin
    c1         = {1'b0, cyc_lim} + 5'd1;
    d1         = {1'b0, acyc_lim} + 5'd1;
    apc_full   = 16'(ap) * 16'(c1);
    apnc_full  = 16'(ap) * 16'(nc);
    apcna_full = 20'(apc) * 20'(na);
    len_full   = 20'(apc) * 20'(d1);
    ind_sum    = IND_W'(apcna) + IND_W'(apnc) + IND_W'(tri_hi) + IND_W'(lo);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (accept) state <= F_MUL1;
        F_MUL1: state <= F_MUL2;
        F_MUL2: state <= F_PUSH;
        F_PUSH: if (!full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind   <= kind_next;
      lo     <= first_big ? type_second : type_first;
      tri_hi <= tri6(first_big ? type_first : type_second);
      ap     <= tri6(type_count);
      nc     <= cyclic_bonds[LIM_W-1:0];
      na     <= acyclic_bonds[LIM_W-1:0];
      bi     <= bin_index;
    end
    if (state == F_MUL1) begin
      apc  <= apc_full[APC_W-1:0];
      apnc <= apnc_full[APC_W-1:0];
    end
    if (state == F_MUL2) begin
      apcna <= apcna_full[IND_W-1:0];
      len   <= len_full[IND_W-1:0];
    end
  end

  // job to the queue
  assign push     = (state == F_PUSH) && !full;
  assign job.kind = kind;
  assign job.ind  = (kind == K_READ) ? IND_W'(bi) : ind_sum;
  assign job.len  = len;
  assign job.ap   = ap;
  assign job.apc  = apc;

endmodule

// ===== sv/apdh_fifo.sv =====
// two-entry job queue between front and back
// depends on apdh_pkg
module apdh_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  apdh_pkg::job_t  job_in,
  output logic            full,
  input  logic            pop,
  output apdh_pkg::job_t  head,
  output logic            empty
);
  import apdh_pkg::*;

  job_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slot[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= job_in;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== sv/apdh_back.sv =====
// back end: bin memory access, clear sweep, bit-serial index decode and result register
// depends on apdh_pkg and apdh_ram
module apdh_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          empty,
  input  apdh_pkg::job_t                head,
  output logic                          pop,
  output logic                          sweeping,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          counted,
  output logic [apdh_pkg::BIDX_W-1:0]   descriptor_index,
  output logic [apdh_pkg::CNT_W-1:0]    bin_count,
  output logic [apdh_pkg::TYPE_W-1:0]   type_high,
  output logic [apdh_pkg::TYPE_W-1:0]   type_low,
  output logic [apdh_pkg::LIM_W-1:0]    cyclic_out,
  output logic [7:0]                    acyclic_out
);
  import apdh_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_CLEAR = 3'd1;
  localparam logic [2:0] B_MEM   = 3'd2;
  localparam logic [2:0] B_DIV1  = 3'd3;
  localparam logic [2:0] B_DIV2  = 3'd4;
  localparam logic [2:0] B_ROOT  = 3'd5;
  localparam logic [2:0] B_LO    = 3'd6;
  localparam logic [2:0] B_OUT   = 3'd7;

  localparam logic [4:0] DIV_LAST = 5'(IND_W - 1);
  localparam logic [BIN_AW-1:0] ADDR_LAST = BIN_AW'(BIN_COUNT - 1);

  logic [2:0]        state;
  job_t              cur;
  logic              in_range;
  logic              rd_ok;
  logic [BIN_AW-1:0] clr_addr;
  logic              clr_init;

  logic [IND_W-1:0]  div_num;
  logic [IND_W-1:0]  div_quo;
  logic [APC_W-1:0]  div_rem;
  logic [APC_W-1:0]  div_den;
  logic [4:0]        step;
  logic [TYPE_W-1:0] root;
  logic [AP_W-1:0]   q_rem;

  logic              mem_wr;
  logic [BIN_AW-1:0] mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              mem_rd;
  logic [CNT_W-1:0]  mem_rdata;
  logic [CNT_W-1:0]  inc;

  logic [APC_W:0]    trial;
  logic              ge;
  logic [APC_W:0]    rem_wide;
  logic [APC_W-1:0]  rem_next;
  logic [IND_W-1:0]  quo_next;
  logic [TYPE_W-1:0] cand;
  logic [AP_W-1:0]   lo_wide;

  assign sweeping  = clr_init;
  assign out_valid = state == B_OUT;
  assign pop       = (state == B_IDLE) && !empty;

  // bin memory
  apdh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_rd),
    .rd_addr (head.ind[BIN_AW-1:0]),
    .rd_data (mem_rdata)
  );

  // memory control
  always_comb begin
    inc       = (mem_rdata == CNT_MAX) ? CNT_MAX : mem_rdata + 8'd1;
    mem_rd    = pop && ((head.kind == K_ACC) || (head.kind == K_READ));
    mem_wr    = (state == B_CLEAR) || ((state == B_MEM) && (cur.kind == K_ACC) && in_range);
    mem_waddr = (state == B_CLEAR) ? clr_addr : cur.ind[BIN_AW-1:0];
    mem_wdata = (state == B_CLEAR) ? '0 : inc;
  end

  // restoring divide step and root trial
  always_comb begin
    trial    = {div_rem, div_num[IND_W-1]};
    ge       = trial >= {1'b0, div_den};
    rem_wide = ge ? (trial - {1'b0, div_den}) : trial;
    rem_next = rem_wide[APC_W-1:0];
    quo_next = {div_quo[IND_W-2:0], ge};
    cand     = root | (TYPE_W'(1) << step[2:0]);
    lo_wide  = q_rem - tri6(root);
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      clr_init <= 1'b1;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            unique case (head.kind)
              K_CLEAR: begin
                clr_addr <= '0;
                state    <= B_CLEAR;
              end
              K_NONE:  state <= B_OUT;
              default: state <= B_MEM;
            endcase
          end
        end
        B_CLEAR: begin
          clr_addr <= clr_addr + BIN_AW'(1);
          if (clr_addr == ADDR_LAST) begin
            clr_init <= 1'b0;
            state    <= clr_init ? B_IDLE : B_OUT;
          end
        end
        B_MEM:  state <= (cur.ap == '0) ? B_OUT : B_DIV1;
        B_DIV1: if (step == DIV_LAST) state <= B_DIV2;
        B_DIV2: if (step == DIV_LAST) state <= B_ROOT;
        B_ROOT: if (step == '0) state <= B_LO;
        B_LO:   state <= B_OUT;
        B_OUT:  if (!out_stall) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          cur              <= head;
          in_range         <= (head.kind == K_ACC) && (head.ind < head.len)
                              && (head.ind < IND_W'(BIN_COUNT));
          rd_ok            <= head.ind < IND_W'(BIN_COUNT);
          counted          <= 1'b0;
          bin_count        <= '0;
          type_high        <= '0;
          type_low         <= '0;
          cyclic_out       <= '0;
          acyclic_out      <= '0;
          descriptor_index <= ((head.kind == K_ACC) || (head.kind == K_READ))
                              ? head.ind[BIDX_W-1:0] : '0;
        end
      end
      B_MEM: begin
        if (cur.kind == K_ACC) begin
          if (in_range) begin
            counted   <= 1'b1;
            bin_count <= inc;
          end
        end else if (rd_ok) begin
          bin_count <= mem_rdata;
        end
        div_num <= cur.ind;
        div_den <= cur.apc;
        div_rem <= '0;
        div_quo <= '0;
        step    <= '0;
      end
      B_DIV1: begin
        if (step == DIV_LAST) begin
          // quotient done, start the second divide on the remainder
          acyclic_out <= quo_next[7:0];
          div_num     <= IND_W'(rem_next);
          div_den     <= APC_W'(cur.ap);
          div_rem     <= '0;
          div_quo     <= '0;
          step        <= '0;
        end else begin
          div_num <= div_num << 1;
          div_rem <= rem_next;
          div_quo <= quo_next;
          step    <= step + 5'd1;
        end
      end
      B_DIV2: begin
        if (step == DIV_LAST) begin
          cyclic_out <= quo_next[LIM_W-1:0];
          q_rem      <= rem_next[AP_W-1:0];
          root       <= '0;
          step       <= 5'(TYPE_W - 1);
        end else begin
          div_num <= div_num << 1;
          div_rem <= rem_next;
          div_quo <= quo_next;
          step    <= step + 5'd1;
        end
      end
      B_ROOT: begin
        // one bit of the triangular root a step, high bit first
        if (tri6(cand) <= q_rem) root <= cand;
        step <= step - 5'd1;
      end
      B_LO: begin
        type_high <= root;
        type_low  <= lo_wide[TYPE_W-1:0];
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_counted_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && counted) |-> (bin_count != '0))
    else $error("counted result with zero bin count");
  a_low_not_above_high: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (type_low <= type_high))
    else $error("decoded low type above high type");
`endif

endmodule

// ===== sv/atom_pair_descriptor_histogram_top.sv =====
// top level of the atom-pair descriptor histogram: front, job queue and back
// depends on apdh_pkg, apdh_front, apdh_fifo, apdh_back
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  action, type_first, type_second, bonds, bin_index
//   out      output     out_valid/out_stall  counted, descriptor_index, bin_count, decoded fields
//   cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// after reset the bins are zeroed by a sweep over all BIN_COUNT bins; no word is taken meanwhile
// the front takes a new word only after its two multiply steps and the push, which holds while the queue is full
// accumulate and read go from pop to result through B_MEM, the bit-serial divider that decodes the index
//   twice, the six-step root and B_LO; a zero pair span skips the decode
// clear writes every one of the BIN_COUNT bins, one bin written per cycle
// the two-entry queue lets the front keep accepting while a result waits on out_stall
module atom_pair_descriptor_histogram_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [apdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apdh_pkg::TYPE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [apdh_pkg::TYPE_W-1:0]     type_first,
  input  logic [apdh_pkg::TYPE_W-1:0]     type_second,
  input  logic [7:0]                      cyclic_bonds,
  input  logic [7:0]                      acyclic_bonds,
  input  logic [apdh_pkg::BIDX_W-1:0]     bin_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            counted,
  output logic [apdh_pkg::BIDX_W-1:0]     descriptor_index,
  output logic [apdh_pkg::CNT_W-1:0]      bin_count,
  output logic [apdh_pkg::TYPE_W-1:0]     type_high,
  output logic [apdh_pkg::TYPE_W-1:0]     type_low,
  output logic [apdh_pkg::LIM_W-1:0]      cyclic_out,
  output logic [7:0]                      acyclic_out
);
  import apdh_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  logic sweeping;
  job_t job;
  job_t head;

  // accept and classify
  apdh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .hold          (sweeping),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .type_first    (type_first),
    .type_second   (type_second),
    .cyclic_bonds  (cyclic_bonds),
    .acyclic_bonds (acyclic_bonds),
    .bin_index     (bin_index),
    .push          (push),
    .job           (job),
    .full          (full)
  );

  // job queue
  apdh_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job),
    .full   (full),
    .pop    (pop),
    .head   (head),
    .empty  (empty)
  );

  // carry out and decode
  apdh_back u_back (
    .clk              (clk),
    .rst              (rst),
    .empty            (empty),
    .head             (head),
    .pop              (pop),
    .sweeping         (sweeping),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .counted          (counted),
    .descriptor_index (descriptor_index),
    .bin_count        (bin_count),
    .type_high        (type_high),
    .type_low         (type_low),
    .cyclic_out       (cyclic_out),
    .acyclic_out      (acyclic_out)
  );

endmodule
